// ===== design/r2k_pkg.sv =====
// Package: payload types, ROM contents and kana constants for the romaji converter.
package r2k_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] key;
    } r2k_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } r2k_out_t;

    localparam int RomDepth = 125;
    localparam int RomAw    = 7;

    // ROM entry: romaji up to four letters (zero padded), length, kana up to six bytes.
    typedef struct packed {
        logic [31:0] roma;
        logic [2:0]  rlen;
        logic [47:0] kana;
        logic [2:0]  klen;
    } r2k_rom_t;

    localparam logic [23:0] KanaN     = 24'he38293;
    localparam logic [23:0] KanaTsu   = 24'he381a3;
    localparam logic [23:0] KanaLong  = 24'he383bc;
    localparam logic [23:0] KanaComma = 24'he38081;
    localparam logic [23:0] KanaStop  = 24'he38082;
    localparam logic [23:0] KanaOpen  = 24'he3808c;
    localparam logic [23:0] KanaClose = 24'he3808d;

    function automatic r2k_rom_t mk(input logic [31:0] r, input logic [2:0] rl,
                                    input logic [47:0] k, input logic [2:0] kl);
        r2k_rom_t e;
        e.roma = r; e.rlen = rl; e.kana = k; e.klen = kl;
        return e;
    endfunction

    function automatic r2k_rom_t e1(input logic [7:0] a, input logic [23:0] k);
        return mk({a, 24'h0}, 3'd1, {k, 24'h0}, 3'd3);
    endfunction
    function automatic r2k_rom_t e2(input logic [15:0] a, input logic [23:0] k);
        return mk({a, 16'h0}, 3'd2, {k, 24'h0}, 3'd3);
    endfunction
    function automatic r2k_rom_t e3(input logic [23:0] a, input logic [23:0] k);
        return mk({a, 8'h0}, 3'd3, {k, 24'h0}, 3'd3);
    endfunction
    function automatic r2k_rom_t y2(input logic [15:0] a, input logic [23:0] k,
                                    input logic [23:0] s);
        return mk({a, 16'h0}, 3'd2, {k, s}, 3'd6);
    endfunction
    function automatic r2k_rom_t y3(input logic [23:0] a, input logic [23:0] k,
                                    input logic [23:0] s);
        return mk({a, 8'h0}, 3'd3, {k, s}, 3'd6);
    endfunction

    localparam logic [23:0] SYa = 24'he38283;
    localparam logic [23:0] SYu = 24'he38285;
    localparam logic [23:0] SYo = 24'he38287;

    function automatic r2k_rom_t rom_entry(input logic [RomAw-1:0] idx);
        case (idx)
            7'd0:   return e1("a", 24'he38182);
            7'd1:   return e1("i", 24'he38184);
            7'd2:   return e1("u", 24'he38186);
            7'd3:   return e1("e", 24'he38188);
            7'd4:   return e1("o", 24'he3818a);
            7'd5:   return e2("ka", 24'he3818b);
            7'd6:   return e2("ki", 24'he3818d);
            7'd7:   return e2("ku", 24'he3818f);
            7'd8:   return e2("ke", 24'he38191);
            7'd9:   return e2("ko", 24'he38193);
            7'd10:  return e2("sa", 24'he38195);
            7'd11:  return e3("shi", 24'he38197);
            7'd12:  return e2("si", 24'he38197);
            7'd13:  return e2("su", 24'he38199);
            7'd14:  return e2("se", 24'he3819b);
            7'd15:  return e2("so", 24'he3819d);
            7'd16:  return e2("ta", 24'he3819f);
            7'd17:  return e3("chi", 24'he381a1);
            7'd18:  return e2("ti", 24'he381a1);
            7'd19:  return e3("tsu", 24'he381a4);
            7'd20:  return e2("tu", 24'he381a4);
            7'd21:  return e2("te", 24'he381a6);
            7'd22:  return e2("to", 24'he381a8);
            7'd23:  return e2("na", 24'he381aa);
            7'd24:  return e2("ni", 24'he381ab);
            7'd25:  return e2("nu", 24'he381ac);
            7'd26:  return e2("ne", 24'he381ad);
            7'd27:  return e2("no", 24'he381ae);
            7'd28:  return e2("ha", 24'he381af);
            7'd29:  return e2("hi", 24'he381b2);
            7'd30:  return e2("fu", 24'he381b5);
            7'd31:  return e2("hu", 24'he381b5);
            7'd32:  return e2("he", 24'he381b8);
            7'd33:  return e2("ho", 24'he381bb);
            7'd34:  return e2("ma", 24'he381be);
            7'd35:  return e2("mi", 24'he381bf);
            7'd36:  return e2("mu", 24'he38280);
            7'd37:  return e2("me", 24'he38281);
            7'd38:  return e2("mo", 24'he38282);
            7'd39:  return e2("ya", 24'he38284);
            7'd40:  return e2("yu", 24'he38286);
            7'd41:  return e2("yo", 24'he38288);
            7'd42:  return e2("ra", 24'he38289);
            7'd43:  return e2("ri", 24'he3828a);
            7'd44:  return e2("ru", 24'he3828b);
            7'd45:  return e2("re", 24'he3828c);
            7'd46:  return e2("ro", 24'he3828d);
            7'd47:  return e2("wa", 24'he3828f);
            7'd48:  return e2("wo", 24'he38292);
            7'd49:  return e2("nn", 24'he38293);
            7'd50:  return e2("ga", 24'he3818c);
            7'd51:  return e2("gi", 24'he3818e);
            7'd52:  return e2("gu", 24'he38190);
            7'd53:  return e2("ge", 24'he38192);
            7'd54:  return e2("go", 24'he38194);
            7'd55:  return e2("za", 24'he38196);
            7'd56:  return e2("ji", 24'he38198);
            7'd57:  return e2("zi", 24'he38198);
            7'd58:  return e2("zu", 24'he3819a);
            7'd59:  return e2("ze", 24'he3819c);
            7'd60:  return e2("zo", 24'he3819e);
            7'd61:  return e2("da", 24'he381a0);
            7'd62:  return e2("di", 24'he381a2);
            7'd63:  return e2("du", 24'he381a5);
            7'd64:  return e2("de", 24'he381a7);
            7'd65:  return e2("do", 24'he381a9);
            7'd66:  return e2("ba", 24'he381b0);
            7'd67:  return e2("bi", 24'he381b3);
            7'd68:  return e2("bu", 24'he381b6);
            7'd69:  return e2("be", 24'he381b9);
            7'd70:  return e2("bo", 24'he381bc);
            7'd71:  return e2("pa", 24'he381b1);
            7'd72:  return e2("pi", 24'he381b4);
            7'd73:  return e2("pu", 24'he381b7);
            7'd74:  return e2("pe", 24'he381ba);
            7'd75:  return e2("po", 24'he381bd);
            7'd76:  return y3("kya", 24'he3818d, SYa);
            7'd77:  return y3("kyu", 24'he3818d, SYu);
            7'd78:  return y3("kyo", 24'he3818d, SYo);
            7'd79:  return y3("sha", 24'he38197, SYa);
            7'd80:  return y3("shu", 24'he38197, SYu);
            7'd81:  return y3("sho", 24'he38197, SYo);
            7'd82:  return y3("sya", 24'he38197, SYa);
            7'd83:  return y3("syu", 24'he38197, SYu);
            7'd84:  return y3("syo", 24'he38197, SYo);
            7'd85:  return y3("cha", 24'he381a1, SYa);
            7'd86:  return y3("chu", 24'he381a1, SYu);
            7'd87:  return y3("cho", 24'he381a1, SYo);
            7'd88:  return y3("tya", 24'he381a1, SYa);
            7'd89:  return y3("tyu", 24'he381a1, SYu);
            7'd90:  return y3("tyo", 24'he381a1, SYo);
            7'd91:  return y3("nya", 24'he381ab, SYa);
            7'd92:  return y3("nyu", 24'he381ab, SYu);
            7'd93:  return y3("nyo", 24'he381ab, SYo);
            7'd94:  return y3("hya", 24'he381b2, SYa);
            7'd95:  return y3("hyu", 24'he381b2, SYu);
            7'd96:  return y3("hyo", 24'he381b2, SYo);
            7'd97:  return y3("mya", 24'he381bf, SYa);
            7'd98:  return y3("myu", 24'he381bf, SYu);
            7'd99:  return y3("myo", 24'he381bf, SYo);
            7'd100: return y3("rya", 24'he3828a, SYa);
            7'd101: return y3("ryu", 24'he3828a, SYu);
            7'd102: return y3("ryo", 24'he3828a, SYo);
            7'd103: return y3("gya", 24'he3818e, SYa);
            7'd104: return y3("gyu", 24'he3818e, SYu);
            7'd105: return y3("gyo", 24'he3818e, SYo);
            7'd106: return y2("ja", 24'he38198, SYa);
            7'd107: return y2("ju", 24'he38198, SYu);
            7'd108: return y2("jo", 24'he38198, SYo);
            7'd109: return y3("bya", 24'he381b3, SYa);
            7'd110: return y3("byu", 24'he381b3, SYu);
            7'd111: return y3("byo", 24'he381b3, SYo);
            7'd112: return y3("pya", 24'he381b4, SYa);
            7'd113: return y3("pyu", 24'he381b4, SYu);
            7'd114: return y3("pyo", 24'he381b4, SYo);
            7'd115: return e3("xtu", 24'he381a3);
            7'd116: return mk("xtsu", 3'd4, {24'he381a3, 24'h0}, 3'd3);
            7'd117: return e2("xa", 24'he38181);
            7'd118: return e2("xi", 24'he38183);
            7'd119: return e2("xu", 24'he38185);
            7'd120: return e2("xe", 24'he38187);
            7'd121: return e2("xo", 24'he38189);
            7'd122: return e3("xya", SYa);
            7'd123: return e3("xyu", SYu);
            7'd124: return e3("xyo", SYo);
            default: return mk(32'h0, 3'd0, 48'h0, 3'd0);
        endcase
    endfunction

    function automatic logic is_vowel(input logic [7:0] c);
        return (c == "a") || (c == "i") || (c == "u") || (c == "e") || (c == "o");
    endfunction

endpackage

// ===== design/r2k_scan.sv =====
// ROM scan unit: one entry compared a cycle, reports full match and prefix hits.
module r2k_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [23:0]           pattern,
    input  logic [1:0]            plen,
    output logic                  done,
    output logic                  full_hit,
    output logic                  pre_hit,
    output logic [47:0]           kana,
    output logic [2:0]            klen
);
    import r2k_pkg::*;

    logic             busy_reg, busy_next;
    logic [RomAw-1:0] idx_reg, idx_next;
    logic             full_reg, full_next;
    logic             pre_reg, pre_next;
    logic [47:0]      kana_reg, kana_next;
    logic [2:0]       klen_reg, klen_next;
    r2k_rom_t         ent;
    logic [23:0]      mask;
    logic             head_eq;

    always_comb
    begin
        ent = rom_entry(idx_reg);
        case (plen)
            2'd1:    mask = 24'hff0000;
            2'd2:    mask = 24'hffff00;
            default: mask = 24'hffffff;
        endcase
        head_eq = ((ent.roma[31:8] ^ pattern) & mask) == 24'h0;
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        full_next = full_reg;
        pre_next  = pre_reg;
        kana_next = kana_reg;
        klen_next = klen_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            full_next = 1'b0;
            pre_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (head_eq && ent.rlen == {1'b0, plen} && !full_reg)
            begin
                full_next = 1'b1;
                kana_next = ent.kana;
                klen_next = ent.klen;
            end
            if (head_eq && ent.rlen > {1'b0, plen})
                pre_next = 1'b1;
            if (idx_reg == RomAw'(RomDepth - 1))
            begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + 1'b1;
        end
        else if (idx_reg == RomAw'(RomDepth))
        begin
            done     = 1'b1;
            idx_next = '0;
        end
    end

    assign full_hit = full_reg;
    assign pre_hit  = pre_reg;
    assign kana     = kana_reg;
    assign klen     = klen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            full_reg <= 1'b0;
            pre_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            full_reg <= full_next;
            pre_reg  <= pre_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kana_reg <= kana_next;
        klen_reg <= klen_next;
    end

endmodule

// ===== design/romaji_to_kana_converter_unit.sv =====
// Top level: romaji key stream to UTF-8 hiragana byte stream.
//
// Input channel (in_valid/in_ready, payload in): one item is a key byte or a
// flush command. Output channel (out_valid/out_ready, payload out): kana or
// passed bytes, last set on the final byte caused by one input item.
// One item is in flight at a time; in_ready is high only when idle.
// Punctuation, pass-through and flush results start the cycle after
// acceptance. A lowercase letter that reaches the ROM takes a scan of 125
// entries, one per cycle, then a report from the scan unit; on a full match
// its bytes are then offered in order (up to six), each held until taken.
// The ROM scan unit sets the rate: no new item is accepted until the
// current one is through its scan and emit.
// Reset clears the pending letter count and the waiting n flag; held letters
// themselves are not cleared. When the receiver stalls, the current byte is
// held on out and the block simply waits; nothing is dropped.
module romaji_to_kana_converter_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  r2k_pkg::r2k_in_t  in,
    output logic              out_valid,
    input  logic              out_ready,
    output r2k_pkg::r2k_out_t out
);
    import r2k_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  let_reg [3];
    logic [7:0]  let_next [3];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wn_reg, wn_next;
    // emit buffer: up to six bytes, left aligned
    logic [47:0] buf_reg, buf_next;
    logic [2:0]  blen_reg, blen_next;
    logic [2:0]  bpos_reg, bpos_next;
    // pattern under scan
    logic [23:0] pat_reg, pat_next;
    logic [1:0]  plen_reg, plen_next;

    logic        scan_start;
    logic        scan_done, full_hit, pre_hit;
    logic [47:0] scan_kana;
    logic [2:0]  scan_klen;

    r2k_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .pattern  (pat_reg),
        .plen     (plen_reg),
        .done     (scan_done),
        .full_hit (full_hit),
        .pre_hit  (pre_hit),
        .kana     (scan_kana),
        .klen     (scan_klen)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_EMIT);
    assign out.out_byte = buf_reg[47:40];
    assign out.last     = (bpos_reg + 3'd1 == blen_reg);

    always_comb
    begin
        logic [7:0] c;
        logic       go;
        state_next = state_reg;
        let_next   = let_reg;
        cnt_next   = cnt_reg;
        wn_next    = wn_reg;
        buf_next   = buf_reg;
        blen_next  = blen_reg;
        bpos_next  = bpos_reg;
        pat_next   = pat_reg;
        plen_next  = plen_reg;
        scan_start = 1'b0;
        c          = in.key;
        go         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bpos_next = 3'd0;
                    if (in.cmd)
                    begin
                        if (wn_reg)
                        begin
                            cnt_next  = 2'd0;
                            wn_next   = 1'b0;
                            buf_next  = {KanaN, 24'h0};
                            blen_next = 3'd3;
                            state_next = ST_EMIT;
                        end
                    end
                    else if (c < "a" || c > "z")
                    begin
                        cnt_next  = 2'd0;
                        wn_next   = 1'b0;
                        blen_next = 3'd3;
                        state_next = ST_EMIT;
                        if (c == "-")      buf_next = {KanaLong, 24'h0};
                        else if (c == ",") buf_next = {KanaComma, 24'h0};
                        else if (c == ".") buf_next = {KanaStop, 24'h0};
                        else if (c == "[") buf_next = {KanaOpen, 24'h0};
                        else if (c == "]") buf_next = {KanaClose, 24'h0};
                        else if (c == 8'h00) state_next = ST_IDLE;
                        else
                        begin
                            buf_next  = {c, 40'h0};
                            blen_next = 3'd1;
                        end
                    end
                    else if (wn_reg && !(c == "y" || is_vowel(c)))
                    begin
                        // waiting n settled by a consonant
                        wn_next     = 1'b0;
                        buf_next    = {KanaN, 24'h0};
                        blen_next   = 3'd3;
                        state_next  = ST_EMIT;
                        if (c == "n")
                            cnt_next = 2'd0;
                        else
                        begin
                            let_next[0] = c;
                            cnt_next    = 2'd1;
                        end
                    end
                    else
                    begin
                        wn_next = 1'b0;
                        if (cnt_reg == 2'd0 && c == "n")
                        begin
                            let_next[0] = c;
                            cnt_next    = 2'd1;
                            wn_next     = 1'b1;
                        end
                        else if (cnt_reg == 2'd1 && let_reg[0] == c && c != "n"
                                 && !is_vowel(c))
                        begin
                            buf_next   = {KanaTsu, 24'h0};
                            blen_next  = 3'd3;
                            state_next = ST_EMIT;
                        end
                        else
                            go = 1'b1;
                    end
                    if (go)
                    begin
                        // pattern is held letters then new one; a full buffer
                        // has length four, which only xtsu could match
                        case (cnt_reg)
                            2'd0:    pat_next = {c, 16'h0};
                            2'd1:    pat_next = {let_reg[0], c, 8'h0};
                            2'd2:    pat_next = {let_reg[0], let_reg[1], c};
                            default: pat_next = {let_reg[0], let_reg[1], let_reg[2]};
                        endcase
                        plen_next  = cnt_reg + 2'd1;
                        let_next[0] = c;
                        state_next = ST_SCAN;
                        if (cnt_reg == 2'd3)
                        begin
                            // four letters: xtsu is the only candidate
                            state_next = ST_IDLE;
                            cnt_next   = 2'd1;
                            if (let_reg[0] == "x" && let_reg[1] == "t" &&
                                let_reg[2] == "s" && c == "u")
                            begin
                                cnt_next   = 2'd0;
                                buf_next   = {KanaTsu, 24'h0};
                                blen_next  = 3'd3;
                                state_next = ST_EMIT;
                            end
                        end
                        else
                        begin
                            let_next   = let_reg;
                            scan_start = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (full_hit)
                    begin
                        cnt_next   = 2'd0;
                        buf_next   = scan_kana;
                        blen_next  = scan_klen;
                        state_next = ST_EMIT;
                    end
                    else if (pre_hit)
                    begin
                        let_next[0] = pat_reg[23:16];
                        let_next[1] = pat_reg[15:8];
                        let_next[2] = pat_reg[7:0];
                        cnt_next    = plen_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        case (plen_reg)
                            2'd1:    let_next[0] = pat_reg[23:16];
                            2'd2:    let_next[0] = pat_reg[15:8];
                            default: let_next[0] = pat_reg[7:0];
                        endcase
                        cnt_next   = 2'd1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    buf_next  = {buf_reg[39:0], 8'h0};
                    bpos_next = bpos_reg + 3'd1;
                    if (out.last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
            wn_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wn_reg    <= wn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        let_reg  <= let_next;
        buf_reg  <= buf_next;
        blen_reg <= blen_next;
        bpos_reg <= bpos_next;
        pat_reg  <= pat_next;
        plen_reg <= plen_next;
    end

endmodule
